>>> rtl/ray_sphere_intersect_core_assert.svh
// Assertion macros shared by the ray/sphere core.
`ifndef RAY_SPHERE_INTERSECT_CORE_ASSERT_SVH
`define RAY_SPHERE_INTERSECT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RSI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RSI_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define RSI_ASSERT(label, clk, rst_n, prop, msg)
`define RSI_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

>>> rtl/rsi_pkg.sv
package rsi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int CFG_INDEX_W     = 2;

    // Radius after reset: 1.0 in Q16.16
    localparam logic [63:0] RADIUS_RESET = 64'd65536;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } rsi_reg_t;

    // Per-stage control carried along with each request
    typedef struct packed {
        logic valid;
        logic hit;
    } rsi_ctl_t;

endpackage

>>> rtl/rsi_mul_split.sv
// Unsigned multiplier: four registered partial products, registered sum.
module rsi_mul_split
    import rsi_pkg::*;
#(
    parameter int AW = 65,
    parameter int BW = 65
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [AW-1:0]     a,
    input  logic [BW-1:0]     b,
    output logic [AW+BW-1:0]  p
);

    localparam int AL = (AW + 1) / 2;
    localparam int AH = AW - AL;
    localparam int BL = (BW + 1) / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AL+BL-1:0] ll_reg;
    logic [AL+BH-1:0] lh_reg;
    logic [AH+BL-1:0] hl_reg;
    logic [AH+BH-1:0] hh_reg;
    logic [PW-1:0]    p_reg;
    logic [PW-1:0]    p_next;

    // Partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= a[AL-1:0] * b[BL-1:0];
            lh_reg <= a[AL-1:0] * b[BW-1:BL];
            hl_reg <= a[AW-1:AL] * b[BL-1:0];
            hh_reg <= a[AW-1:AL] * b[BW-1:BL];
        end
    end

    // Recombine
    assign p_next = PW'(ll_reg) + (PW'(lh_reg) << BL) + (PW'(hl_reg) << AL)
                  + (PW'(hh_reg) << (AL + BL));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

>>> rtl/rsi_front.sv
// Offset, dot products, quadratic terms and discriminant: six stages.
module rsi_front
    import rsi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] origin_x,
    input  logic signed [COORD_WIDTH-1:0] origin_y,
    input  logic signed [COORD_WIDTH-1:0] origin_z,
    input  logic signed [COORD_WIDTH-1:0] dir_x,
    input  logic signed [COORD_WIDTH-1:0] dir_y,
    input  logic signed [COORD_WIDTH-1:0] dir_z,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic signed [COORD_WIDTH-1:0] center_z,
    input  logic        [COORD_WIDTH-2:0] sphere_radius,
    output rsi_ctl_t                      out_ctl,
    output logic [4*COORD_WIDTH+1:0]      out_q,
    output logic [2*COORD_WIDTH:0]        out_nh,
    output logic [2*COORD_WIDTH-1:0]      out_a
);

    localparam int CW  = COORD_WIDTH;
    localparam int EW  = CW + 1;
    localparam int DSW = 2 * CW;
    localparam int EDW = 2 * CW + 1;
    localparam int ESW = 2 * CW + 2;
    localparam int RSW = 2 * CW - 2;
    localparam int AW  = 2 * CW;
    localparam int HW  = 2 * CW + 2;
    localparam int HMW = HW - 1;
    localparam int CFW = 2 * CW + 3;
    localparam int CMW = CFW - 1;
    localparam int RW  = 2 * HMW;

    // Stage 1: offset from center
    logic                 v1_reg;
    logic signed [EW-1:0] ex_reg, ey_reg, ez_reg;
    logic signed [CW-1:0] dx_reg, dy_reg, dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex_reg <= {origin_x[CW-1], origin_x} - {center_x[CW-1], center_x};
            ey_reg <= {origin_y[CW-1], origin_y} - {center_y[CW-1], center_y};
            ez_reg <= {origin_z[CW-1], origin_z} - {center_z[CW-1], center_z};
            dx_reg <= dir_x;
            dy_reg <= dir_y;
            dz_reg <= dir_z;
        end
    end

    // Stage 2: products
    logic                  v2_reg;
    logic signed [DSW-1:0] dsq_x_reg, dsq_y_reg, dsq_z_reg;
    logic signed [EDW-1:0] ed_x_reg, ed_y_reg, ed_z_reg;
    logic signed [ESW-1:0] esq_x_reg, esq_y_reg, esq_z_reg;
    logic        [RSW-1:0] rsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dsq_x_reg <= dx_reg * dx_reg;
            dsq_y_reg <= dy_reg * dy_reg;
            dsq_z_reg <= dz_reg * dz_reg;
            ed_x_reg  <= ex_reg * dx_reg;
            ed_y_reg  <= ey_reg * dy_reg;
            ed_z_reg  <= ez_reg * dz_reg;
            esq_x_reg <= ex_reg * ex_reg;
            esq_y_reg <= ey_reg * ey_reg;
            esq_z_reg <= ez_reg * ez_reg;
            rsq_reg   <= sphere_radius * sphere_radius;
        end
    end

    // Stage 3: a, h, c and the early hit test
    logic        [AW-1:0]  a_next;
    logic signed [HW-1:0]  h_next;
    logic signed [HW-1:0]  nh_full;
    logic signed [CFW-1:0] c_next;
    logic                  pre_hit;
    rsi_ctl_t              ctl3_reg;
    logic [AW-1:0]         a3_reg;
    logic [HMW-1:0]        hm3_reg;
    logic [CMW-1:0]        cm3_reg;

    assign a_next  = $unsigned(dsq_x_reg) + $unsigned(dsq_y_reg) + $unsigned(dsq_z_reg);
    assign h_next  = HW'(ed_x_reg) + HW'(ed_y_reg) + HW'(ed_z_reg);
    assign c_next  = CFW'(esq_x_reg) + CFW'(esq_y_reg) + CFW'(esq_z_reg)
                   - $signed({{(CFW-RSW){1'b0}}, rsq_reg});
    assign nh_full = -h_next;
    assign pre_hit = (a_next != '0) && !c_next[CFW-1] && (c_next != '0) && h_next[HW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg <= '0;
        end
        else if (en)
        begin
            ctl3_reg.valid <= v2_reg;
            ctl3_reg.hit   <= pre_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a3_reg  <= a_next;
            hm3_reg <= nh_full[HMW-1:0];
            cm3_reg <= c_next[CMW-1:0];
        end
    end

    // Stages 4 and 5: h*h and a*c
    logic [RW-1:0] hsq;
    logic [RW-1:0] ac;

    rsi_mul_split #(.AW(HMW), .BW(HMW)) u_mul_hh
    (
        .clk (clk),
        .en  (en),
        .a   (hm3_reg),
        .b   (hm3_reg),
        .p   (hsq)
    );

    rsi_mul_split #(.AW(AW), .BW(CMW)) u_mul_ac
    (
        .clk (clk),
        .en  (en),
        .a   (a3_reg),
        .b   (cm3_reg),
        .p   (ac)
    );

    rsi_ctl_t       ctl4_reg, ctl5_reg;
    logic [AW-1:0]  a4_reg, a5_reg;
    logic [HMW-1:0] hm4_reg, hm5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end
        else if (en)
        begin
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a4_reg  <= a3_reg;
            a5_reg  <= a4_reg;
            hm4_reg <= hm3_reg;
            hm5_reg <= hm4_reg;
        end
    end

    // Stage 6: quarter discriminant
    logic [RW:0]    diff;
    rsi_ctl_t       ctl6_reg;
    logic [RW-1:0]  q6_reg;
    logic [AW-1:0]  a6_reg;
    logic [HMW-1:0] hm6_reg;

    assign diff = {1'b0, hsq} - {1'b0, ac};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl6_reg <= '0;
        end
        else if (en)
        begin
            ctl6_reg.valid <= ctl5_reg.valid;
            ctl6_reg.hit   <= ctl5_reg.hit && !diff[RW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q6_reg  <= diff[RW-1:0];
            a6_reg  <= a5_reg;
            hm6_reg <= hm5_reg;
        end
    end

    assign out_ctl = ctl6_reg;
    assign out_q   = q6_reg;
    assign out_nh  = hm6_reg;
    assign out_a   = a6_reg;

endmodule

>>> rtl/rsi_sqrt_pipe.sv
// Integer square root, one root bit per stage.
module rsi_sqrt_pipe
    import rsi_pkg::*;
#(
    parameter int RW = 130,
    parameter int XW = 129
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  rsi_ctl_t        in_ctl,
    input  logic [RW-1:0]   in_rad,
    input  logic [XW-1:0]   in_side,
    output rsi_ctl_t        out_ctl,
    output logic [RW/2-1:0] out_root,
    output logic [XW-1:0]   out_side
);

    localparam int SW  = RW / 2;
    localparam int RMW = SW + 3;

    rsi_ctl_t       ctl_reg  [SW];
    logic [RW-1:0]  rad_reg  [SW];
    logic [RMW-1:0] rem_reg  [SW];
    logic [SW-1:0]  root_reg [SW];
    logic [XW-1:0]  side_reg [SW];

    for (genvar k = 0; k < SW; k++)
    begin : g_stage
        rsi_ctl_t       ctl_prev;
        logic [RW-1:0]  rad_prev;
        logic [RMW-1:0] rem_prev;
        logic [SW-1:0]  root_prev;
        logic [XW-1:0]  side_prev;
        logic [RMW-1:0] rem_sh;
        logic [RMW-1:0] trial;
        logic           ge;
        logic [RMW-1:0] rem_next;
        logic [SW-1:0]  root_next;
        logic [RW-1:0]  rad_next;

        if (k == 0)
        begin : g_first
            assign ctl_prev  = in_ctl;
            assign rad_prev  = in_rad;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign side_prev = in_side;
        end
        else
        begin : g_rest
            assign ctl_prev  = ctl_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        // Bring down two radicand bits, try root*4+1
        assign rem_sh    = {rem_prev[RMW-3:0], rad_prev[RW-1:RW-2]};
        assign trial     = {1'b0, root_prev, 2'b01};
        assign ge        = (rem_sh >= trial);
        assign rem_next  = ge ? (rem_sh - trial) : rem_sh;
        assign root_next = {root_prev[SW-2:0], ge};
        assign rad_next  = {rad_prev[RW-3:0], 2'b00};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else if (en)
            begin
                ctl_reg[k] <= ctl_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= rad_next;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_ctl  = ctl_reg[SW-1];
    assign out_root = root_reg[SW-1];
    assign out_side = side_reg[SW-1];

endmodule

>>> rtl/rsi_div_pipe.sv
// Nearest root: numerator stage, overflow check, one quotient bit per stage.
module rsi_div_pipe
    import rsi_pkg::*;
#(
    parameter int HMW = 65,
    parameter int AW  = 64,
    parameter int FB  = 16,
    parameter int DW  = 31
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  rsi_ctl_t       in_ctl,
    input  logic [HMW-1:0] in_nh,
    input  logic [HMW-1:0] in_root,
    input  logic [AW-1:0]  in_den,
    output rsi_ctl_t       out_ctl,
    output logic           out_big,
    output logic [DW-1:0]  out_quot
);

    localparam int NW = HMW + FB;
    localparam int TW = AW + DW;

    // Numerator: (-h - s) scaled to the fraction
    rsi_ctl_t       ctlp_reg;
    logic [NW-1:0]  num_reg;
    logic [AW-1:0]  denp_reg;
    logic [HMW-1:0] nd_next;

    assign nd_next = in_nh - in_root;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctlp_reg <= '0;
        end
        else if (en)
        begin
            ctlp_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= {nd_next, {FB{1'b0}}};
            denp_reg <= in_den;
        end
    end

    // Overflow check: quotient would not fit
    rsi_ctl_t      ctlc_reg;
    logic          bigc_reg;
    logic [TW-1:0] remc_reg;
    logic [AW-1:0] denc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctlc_reg <= '0;
        end
        else if (en)
        begin
            ctlc_reg <= ctlp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bigc_reg <= ((num_reg >> DW) >= denp_reg);
            remc_reg <= TW'(num_reg);
            denc_reg <= denp_reg;
        end
    end

    // Restoring division stages
    rsi_ctl_t      ctl_reg  [DW];
    logic          big_reg  [DW];
    logic [TW-1:0] rem_reg  [DW];
    logic [AW-1:0] den_reg  [DW];
    logic [DW-1:0] quot_reg [DW];

    for (genvar j = 0; j < DW; j++)
    begin : g_stage
        rsi_ctl_t      ctl_prev;
        logic          big_prev;
        logic [TW-1:0] rem_prev;
        logic [AW-1:0] den_prev;
        logic [DW-1:0] quot_prev;
        logic [TW-1:0] shifted;
        logic          ge;

        if (j == 0)
        begin : g_first
            assign ctl_prev  = ctlc_reg;
            assign big_prev  = bigc_reg;
            assign rem_prev  = remc_reg;
            assign den_prev  = denc_reg;
            assign quot_prev = '0;
        end
        else
        begin : g_rest
            assign ctl_prev  = ctl_reg[j-1];
            assign big_prev  = big_reg[j-1];
            assign rem_prev  = rem_reg[j-1];
            assign den_prev  = den_reg[j-1];
            assign quot_prev = quot_reg[j-1];
        end

        assign shifted = TW'(den_prev) << (DW - 1 - j);
        assign ge      = (rem_prev >= shifted);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[j] <= '0;
            end
            else if (en)
            begin
                ctl_reg[j] <= ctl_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                big_reg[j]  <= big_prev;
                rem_reg[j]  <= ge ? (rem_prev - shifted) : rem_prev;
                den_reg[j]  <= den_prev;
                quot_reg[j] <= {quot_prev[DW-2:0], ge};
            end
        end
    end

    assign out_ctl  = ctl_reg[DW-1];
    assign out_big  = big_reg[DW-1];
    assign out_quot = quot_reg[DW-1];

endmodule

>>> rtl/ray_sphere_intersect_core.sv
// Ray/sphere intersection core. Each request is one ray (origin and direction, signed
// fixed point); the sphere center and radius sit in four configuration registers (index 0..2
// center x/y/z, 3 radius; ready is always high). One ray is taken every cycle while in_stall is low and its
// result (hit, distance to the nearest strictly positive root) passes through six stages of offsets,
// products and discriminant, one stage per root bit of the square root, two setup stages and one
// stage per quotient bit of the division, and the output register. A miss (negative discriminant, zero
// direction, origin inside, on or behind the sphere) gives hit 0 and the largest distance; a distance
// that does not fit saturates with hit still 1. A stalled output fills a one-entry skid register,
// after which the input is stalled until it drains.
module ray_sphere_intersect_core
    import rsi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] origin_x,
    input  logic signed [COORD_WIDTH-1:0] origin_y,
    input  logic signed [COORD_WIDTH-1:0] origin_z,
    input  logic signed [COORD_WIDTH-1:0] dir_x,
    input  logic signed [COORD_WIDTH-1:0] dir_y,
    input  logic signed [COORD_WIDTH-1:0] dir_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [COORD_WIDTH-2:0]        distance
);

`include "ray_sphere_intersect_core_assert.svh"

    localparam int CW  = COORD_WIDTH;
    localparam int AW  = 2 * CW;
    localparam int HMW = 2 * CW + 1;
    localparam int RW  = 2 * HMW;
    localparam int XW  = HMW + AW;
    localparam int DW  = CW - 1;
    localparam logic [DW-1:0] DIST_MAX = '1;

    // Configuration registers
    logic signed [CW-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic        [DW-1:0] sphere_radius_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg      <= '0;
            center_y_reg      <= '0;
            center_z_reg      <= '0;
            sphere_radius_reg <= RADIUS_RESET[DW-1:0];
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (rsi_reg_t'(cfg_index))
                REG_CENTER_X: center_x_reg      <= cfg_data;
                REG_CENTER_Y: center_y_reg      <= cfg_data;
                REG_CENTER_Z: center_z_reg      <= cfg_data;
                REG_RADIUS:   sphere_radius_reg <= cfg_data[DW-1:0];
                default:      ;
            endcase
        end
    end

    // Pipeline advances while the skid register is empty
    logic skid_valid_reg;
    logic en;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    rsi_ctl_t       f_ctl;
    logic [RW-1:0]  f_q;
    logic [HMW-1:0] f_nh;
    logic [AW-1:0]  f_a;

    rsi_front #(.COORD_WIDTH(CW)) u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (in_valid),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .origin_z      (origin_z),
        .dir_x         (dir_x),
        .dir_y         (dir_y),
        .dir_z         (dir_z),
        .center_x      (center_x_reg),
        .center_y      (center_y_reg),
        .center_z      (center_z_reg),
        .sphere_radius (sphere_radius_reg),
        .out_ctl       (f_ctl),
        .out_q         (f_q),
        .out_nh        (f_nh),
        .out_a         (f_a)
    );

    rsi_ctl_t       s_ctl;
    logic [HMW-1:0] s_root;
    logic [XW-1:0]  s_side;

    rsi_sqrt_pipe #(.RW(RW), .XW(XW)) u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_ctl   (f_ctl),
        .in_rad   (f_q),
        .in_side  ({f_nh, f_a}),
        .out_ctl  (s_ctl),
        .out_root (s_root),
        .out_side (s_side)
    );

    rsi_ctl_t      d_ctl;
    logic          d_big;
    logic [DW-1:0] d_quot;

    rsi_div_pipe #(.HMW(HMW), .AW(AW), .FB(FRAC_BITS), .DW(DW)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_ctl   (s_ctl),
        .in_nh    (s_side[XW-1:AW]),
        .in_root  (s_root),
        .in_den   (s_side[AW-1:0]),
        .out_ctl  (d_ctl),
        .out_big  (d_big),
        .out_quot (d_quot)
    );

    // Final result with miss and overflow saturation
    logic          res_hit;
    logic [DW-1:0] res_dist;

    assign res_hit  = d_ctl.hit;
    assign res_dist = (!d_ctl.hit || d_big) ? DIST_MAX : d_quot;

    // Output register plus skid
    logic          out_valid_reg;
    logic          out_hit_reg, skid_hit_reg;
    logic [DW-1:0] out_dist_reg, skid_dist_reg;
    logic          out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || d_ctl.valid;
            skid_valid_reg <= 1'b0;
        end
        else if (en && d_ctl.valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_hit_reg  <= skid_valid_reg ? skid_hit_reg : res_hit;
            out_dist_reg <= skid_valid_reg ? skid_dist_reg : res_dist;
        end
        else if (en)
        begin
            skid_hit_reg  <= res_hit;
            skid_dist_reg <= res_dist;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = out_hit_reg;
    assign distance  = out_dist_reg;

    `RSI_ASSERT(a_skid_implies_out, clk, rst_n, skid_valid_reg |-> out_valid_reg, "skid holds a result while output is empty")
    `RSI_ASSERT(a_miss_saturates, clk, rst_n, (out_valid_reg && !out_hit_reg) |-> (out_dist_reg == DIST_MAX), "miss without saturated distance")
    `RSI_ASSERT_NEXT(a_skid_kept, clk, rst_n, (skid_valid_reg && out_stall), skid_valid_reg, "skid result dropped under stall")

endmodule
